### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/bca_pkg.sv
// ----------------------------------------------------------------------------
// bca_pkg
// shared constants, types and codes of the bandwidth counter accumulator
// ----------------------------------------------------------------------------
package bca_pkg;

    localparam int NUM_IDS       = 256;
    localparam int COUNTER_WIDTH = 24;
    localparam int ID_W          = $clog2(NUM_IDS);
    localparam int SLOT_W        = ID_W + 1;
    localparam int DEPTH         = 2 * NUM_IDS;
    localparam int BPU_W         = 16;
    localparam int TOTAL_W       = 64;
    localparam int PROD_W        = COUNTER_WIDTH + BPU_W;
    localparam int PADDR_W       = 3;

    localparam logic [BPU_W-1:0] BPU_RESET = 16'd64;

    // register index codes, taken from paddr[2]
    localparam logic REG_BYTES_PER_UNIT = 1'b0;

    typedef logic [SLOT_W-1:0]        slot_t;
    typedef logic [COUNTER_WIDTH-1:0] count_t;
    typedef logic [TOTAL_W-1:0]       total_t;
    typedef logic [BPU_W-1:0]         bpu_t;
    typedef logic [PROD_W-1:0]        prod_t;

    typedef struct packed {
        count_t count;
        total_t total;
    } entry_t;

    typedef struct packed {
        logic   en;
        slot_t  addr;
        entry_t data;
    } tbl_wr_t;

endpackage

### sv/bca_cfg.sv
// ----------------------------------------------------------------------------
// bca_cfg
// apb register file holding the bytes per counter unit scale
// ----------------------------------------------------------------------------
module bca_cfg
    import bca_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output bpu_t               bytes_per_unit
);

    bpu_t bpu_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpu_reg <= BPU_RESET;
        end
        else if (wr_en && (paddr[2] == REG_BYTES_PER_UNIT))
        begin
            bpu_reg <= pwdata[BPU_W-1:0];
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_BYTES_PER_UNIT: prdata = 32'(bpu_reg);
            default:            prdata = '0;
        endcase
    end

    assign bytes_per_unit = bpu_reg;

endmodule

### sv/bca_table.sv
// ----------------------------------------------------------------------------
// bca_table
// per slot store of last counter sample and byte total, registered read
// ----------------------------------------------------------------------------
module bca_table
    import bca_pkg::*;
(
    input  logic    clk,
    input  logic    rd_en,
    input  slot_t   rd_addr,
    input  tbl_wr_t wr,
    output entry_t  rd_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/bca_datapath.sv
// ----------------------------------------------------------------------------
// bca_datapath
// two stage delta, scale and accumulate with write-back forwarding
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bca_datapath
    import bca_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    in_update,
    input  slot_t   in_slot,
    input  count_t  in_sample,
    input  logic    in_flag,
    input  bpu_t    bytes_per_unit,
    input  entry_t  rd_data,
    output tbl_wr_t wr,
    output logic    result_valid,
    output total_t  byte_total,
    output logic    sample_rejected
);

    // stage 1: table data arrives
    logic   s1_valid_reg;
    logic   s1_update_reg;
    slot_t  s1_slot_reg;
    count_t s1_sample_reg;
    logic   s1_flag_reg;

    // stage 2: product ready, accumulate and write back
    logic   s2_valid_reg;
    logic   s2_update_reg;
    slot_t  s2_slot_reg;
    count_t s2_sample_reg;
    logic   s2_flag_reg;
    prod_t  s2_prod_reg;
    total_t s2_total_reg;

    // last write to the table
    logic   wb_valid_reg;
    slot_t  wb_slot_reg;
    entry_t wb_data_reg;

    logic   result_valid_reg;
    total_t byte_total_reg;
    logic   rejected_reg;

    logic   s2_hit1;
    logic   wb_hit1;
    logic   wb_hit2;
    count_t prev_count;
    count_t delta;
    total_t s1_total;
    prod_t  prod_next;
    total_t s2_total;
    total_t total_next;

    always_comb
    begin
        s2_hit1    = s2_valid_reg && !s2_flag_reg && (s2_slot_reg == s1_slot_reg);
        wb_hit1    = wb_valid_reg && (wb_slot_reg == s1_slot_reg);
        prev_count = s2_hit1 ? s2_sample_reg :
                     (wb_hit1 ? wb_data_reg.count : rd_data.count);
        s1_total   = wb_hit1 ? wb_data_reg.total : rd_data.total;
        delta      = s1_sample_reg - prev_count;
        prod_next  = PROD_W'(delta) * PROD_W'(bytes_per_unit);
    end

    always_comb
    begin
        wb_hit2  = wb_valid_reg && (wb_slot_reg == s2_slot_reg);
        s2_total = wb_hit2 ? wb_data_reg.total : s2_total_reg;
        if (s2_flag_reg)
        begin
            total_next = s2_total;
        end
        else if (s2_update_reg)
        begin
            total_next = s2_total + TOTAL_W'(s2_prod_reg);
        end
        else
        begin
            total_next = '0;
        end
        wr.en         = s2_valid_reg && !s2_flag_reg;
        wr.addr       = s2_slot_reg;
        wr.data.count = s2_sample_reg;
        wr.data.total = total_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            wb_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= in_valid;
            s2_valid_reg     <= s1_valid_reg;
            wb_valid_reg     <= wr.en;
            result_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            s1_update_reg <= in_update;
            s1_slot_reg   <= in_slot;
            s1_sample_reg <= in_sample;
            s1_flag_reg   <= in_flag;
        end
        if (s1_valid_reg)
        begin
            s2_update_reg <= s1_update_reg;
            s2_slot_reg   <= s1_slot_reg;
            s2_sample_reg <= s1_sample_reg;
            s2_flag_reg   <= s1_flag_reg;
            s2_prod_reg   <= prod_next;
            s2_total_reg  <= s1_total;
        end
        if (wr.en)
        begin
            wb_slot_reg <= wr.addr;
            wb_data_reg <= wr.data;
        end
        if (s2_valid_reg)
        begin
            byte_total_reg <= total_next;
            rejected_reg   <= s2_flag_reg;
        end
    end

    assign result_valid    = result_valid_reg;
    assign byte_total      = byte_total_reg;
    assign sample_rejected = rejected_reg;

    `ASSERT_NEXT(a_s1_to_s2, s1_valid_reg, s2_valid_reg, "stage 1 beat lost")
    `ASSERT_NEXT(a_s2_to_out, s2_valid_reg, result_valid_reg, "stage 2 beat lost")
    `ASSERT_CLK(a_reject_no_write, !(result_valid_reg && rejected_reg) || !wb_valid_reg,
                "rejected sample wrote the table")

endmodule

### sv/bandwidth_counter_accumulator.sv
// ----------------------------------------------------------------------------
// bandwidth_counter_accumulator
// per id wrapping counter delta accumulator for local and total bandwidth
// ----------------------------------------------------------------------------
// an accepted beat passes stage 1, stage 2 and the result register
// throughput: one beat per cycle; busy never rises, the table read-modify-write
//   forwards from the stage in flight and from the last table write
// reset: pipeline cleared, bytes_per_unit set to 64, table undefined until init
// the receiver cannot stall: each result stands for one cycle only
module bandwidth_counter_accumulator
    import bca_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               req_type,
    input  logic [7:0]         monitor_id,
    input  logic               event_is_local,
    input  logic [23:0]        raw_count,
    input  logic               sample_error,
    input  logic               sample_unavailable,
    output logic               result_valid,
    output logic [63:0]        byte_total,
    output logic               sample_rejected,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    bpu_t            bytes_per_unit;
    entry_t          rd_data;
    tbl_wr_t         wr;
    logic            accept;
    logic [ID_W-1:0] id_wrapped;
    slot_t           slot;
    count_t          sample;
    logic            flagged;

    assign busy       = 1'b0;
    assign accept     = start && !busy;
    assign id_wrapped = ID_W'(32'(monitor_id) % 32'(NUM_IDS));
    assign slot       = {event_is_local, id_wrapped};
    assign sample     = COUNTER_WIDTH'(raw_count);
    assign flagged    = sample_error || sample_unavailable;

    bca_cfg u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .bytes_per_unit (bytes_per_unit)
    );

    bca_table u_table (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (slot),
        .wr      (wr),
        .rd_data (rd_data)
    );

    bca_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (accept),
        .in_update       (req_type),
        .in_slot         (slot),
        .in_sample       (sample),
        .in_flag         (flagged),
        .bytes_per_unit  (bytes_per_unit),
        .rd_data         (rd_data),
        .wr              (wr),
        .result_valid    (result_valid),
        .byte_total      (byte_total),
        .sample_rejected (sample_rejected)
    );

endmodule

### dv/bandwidth_counter_accumulator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bandwidth_counter_accumulator_test
// self-checking bench for the per id counter delta accumulator: drives init,
// update and flagged samples on both tables, predicts each byte total and
// reject bit, and checks every result strobe in order; bytes_per_unit is
// changed between phases over the apb port, sender idling varies per phase
// ----------------------------------------------------------------------------
module bandwidth_counter_accumulator_test;
    import bca_pkg::*;

    localparam logic REQ_INIT   = 1'b0;
    localparam logic REQ_UPDATE = 1'b1;

    localparam logic [PADDR_W-1:0] ADDR_BPU    = 3'd0;
    localparam logic [PADDR_W-1:0] ADDR_UNUSED = 3'd4;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_BEATS = 240;

    typedef struct packed {
        total_t total;
        logic   rejected;
    } bw_result_t;

    class bw_scoreboard;
        count_t     last_count [DEPTH];
        total_t     byte_sum [DEPTH];
        bpu_t       scale;
        bw_result_t pending [$];
        int         errors;

        function new();
            scale  = BPU_RESET;
            errors = 0;
            foreach (last_count[i])
            begin
                last_count[i] = '0;
                byte_sum[i]   = '0;
            end
        endfunction

        function void write_reg(logic [PADDR_W-1:0] addr, logic [31:0] data);
            if (addr[2] == REG_BYTES_PER_UNIT)
                scale = data[BPU_W-1:0];
        endfunction

        function void note_request(logic rt, logic [7:0] id, logic is_loc,
                                   count_t raw, logic err, logic unav);
            slot_t      slot;
            count_t     delta;
            bw_result_t res;
            slot = {is_loc, id};
            if (err || unav)
            begin
                res.total    = byte_sum[slot];
                res.rejected = 1'b1;
            end
            else
            begin
                if (rt == REQ_INIT)
                    byte_sum[slot] = '0;
                else
                begin
                    delta          = raw - last_count[slot];
                    byte_sum[slot] = byte_sum[slot] + total_t'(delta) * total_t'(scale);
                end
                last_count[slot] = raw;
                res.total        = byte_sum[slot];
                res.rejected     = 1'b0;
            end
            pending.push_back(res);
        endfunction

        function void check_result(total_t total, logic rejected);
            bw_result_t exp_res;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result beat, byte_total %h", $time, total);
                errors++;
                return;
            end
            exp_res = pending.pop_front();
            if (total !== exp_res.total)
            begin
                $display("%0t: byte_total expected %h actual %h",
                         $time, exp_res.total, total);
                errors++;
            end
            if (rejected !== exp_res.rejected)
            begin
                $display("%0t: sample_rejected expected %b actual %b",
                         $time, exp_res.rejected, rejected);
                errors++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               req_type = 1'b0;
    logic [7:0]         monitor_id = '0;
    logic               event_is_local = 1'b0;
    logic [23:0]        raw_count = '0;
    logic               sample_error = 1'b0;
    logic               sample_unavailable = 1'b0;
    logic               result_valid;
    logic [63:0]        byte_total;
    logic               sample_rejected;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    bw_scoreboard sb;
    int           cycles = 0;
    bit           seen_init [DEPTH];
    count_t       gen_prev [DEPTH];

    bandwidth_counter_accumulator uut (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .req_type           (req_type),
        .monitor_id         (monitor_id),
        .event_is_local     (event_is_local),
        .raw_count          (raw_count),
        .sample_error       (sample_error),
        .sample_unavailable (sample_unavailable),
        .result_valid       (result_valid),
        .byte_total         (byte_total),
        .sample_rejected    (sample_rejected),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("bandwidth_counter_accumulator test failed");
            $finish;
        end
    end

    // beat accept and result check, pre-edge values
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_request(req_type, monitor_id, event_is_local, raw_count,
                                sample_error, sample_unavailable);
            if (result_valid)
                sb.check_result(byte_total, sample_rejected);
        end
    end

    task automatic send_beat(logic rt, logic [7:0] id, logic is_loc, count_t raw,
                             logic err, logic unav);
        slot_t slot;
        slot               = {is_loc, id};
        start              <= 1'b1;
        req_type           <= rt;
        monitor_id         <= id;
        event_is_local     <= is_loc;
        raw_count          <= raw;
        sample_error       <= err;
        sample_unavailable <= unav;
        do
            @(posedge clk);
        while (busy);
        if (!err && !unav)
        begin
            seen_init[slot] = 1'b1;
            gen_prev[slot]  = raw;
        end
    endtask

    task automatic idle_gap(int idle_pct);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic apb_write(logic [PADDR_W-1:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.write_reg(addr, data);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_check_read(logic [PADDR_W-1:0] addr);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata[BPU_W-1:0] !== sb.scale)
        begin
            $display("%0t: bytes_per_unit read expected %h actual %h",
                     $time, sb.scale, prdata[BPU_W-1:0]);
            sb.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_scale(bpu_t value);
        wait_drained();
        apb_write(ADDR_BPU, {16'($urandom), value});
        apb_check_read(ADDR_BPU);
    endtask

    task automatic run_phase(int beats, int idle_pct);
        slot_t  hot_slots [8];
        slot_t  slot;
        logic   rt;
        logic   err;
        logic   unav;
        count_t raw;
        int     roll;
        foreach (hot_slots[i])
            hot_slots[i] = slot_t'($urandom);
        for (int n = 0; n < beats; n++)
        begin
            if ($urandom_range(99) < 80)
                slot = hot_slots[$urandom_range(7)];
            else
                slot = slot_t'($urandom);
            case ($urandom_range(3))
                0:       raw = count_t'($urandom);
                1:       raw = gen_prev[slot] + count_t'($urandom_range(255));
                2:       raw = gen_prev[slot] - count_t'($urandom_range(1, 16));
                default: raw = {COUNTER_WIDTH{1'($urandom_range(1))}};
            endcase
            err  = 1'b0;
            unav = 1'b0;
            rt   = REQ_UPDATE;
            roll = $urandom_range(99);
            if (!seen_init[slot] || roll < 10)
                rt = REQ_INIT;
            else if (roll >= 85)
            begin
                rt = 1'($urandom_range(1));
                {unav, err} = 2'($urandom_range(1, 3));
            end
            send_beat(rt, slot[ID_W-1:0], slot[ID_W], raw, err, unav);
            if ((n / 40) % 3 != 2)
                idle_gap(idle_pct);
        end
        start <= 1'b0;
    endtask

    initial
    begin
        sb = new();
        foreach (seen_init[i])
        begin
            seen_init[i] = 1'b0;
            gen_prev[i]  = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        apb_check_read(ADDR_BPU);

        // directed beats at the reset scale
        send_beat(REQ_INIT,   8'h00, 1'b0, 24'h000000, 1'b0, 1'b0);
        send_beat(REQ_UPDATE, 8'h00, 1'b0, 24'hFFFFFF, 1'b0, 1'b0);
        send_beat(REQ_UPDATE, 8'h00, 1'b0, 24'h000000, 1'b0, 1'b0);
        send_beat(REQ_UPDATE, 8'h00, 1'b0, 24'h000000, 1'b0, 1'b0);
        send_beat(REQ_INIT,   8'hFF, 1'b1, 24'hFFFFFF, 1'b0, 1'b0);
        send_beat(REQ_UPDATE, 8'hFF, 1'b1, 24'hFFFFFE, 1'b0, 1'b0);
        send_beat(REQ_UPDATE, 8'h00, 1'b0, 24'h000123, 1'b1, 1'b0);
        send_beat(REQ_INIT,   8'h00, 1'b0, 24'h000005, 1'b0, 1'b1);
        send_beat(REQ_UPDATE, 8'hFF, 1'b1, 24'h000000, 1'b1, 1'b1);
        send_beat(REQ_UPDATE, 8'h00, 1'b0, 24'h00000A, 1'b0, 1'b0);
        send_beat(REQ_INIT,   8'h00, 1'b1, 24'h123456, 1'b0, 1'b0);
        send_beat(REQ_UPDATE, 8'h00, 1'b1, 24'h123455, 1'b0, 1'b0);
        send_beat(REQ_INIT,   8'hAA, 1'b0, 24'h555555, 1'b0, 1'b0);
        send_beat(REQ_UPDATE, 8'hAA, 1'b0, 24'hAAAAAA, 1'b0, 1'b0);
        send_beat(REQ_INIT,   8'h55, 1'b1, 24'hAAAAAA, 1'b0, 1'b0);
        send_beat(REQ_UPDATE, 8'h55, 1'b1, 24'h555555, 1'b0, 1'b0);
        send_beat(REQ_UPDATE, 8'h00, 1'b0, 24'h00000B, 1'b0, 1'b0);
        send_beat(REQ_UPDATE, 8'h00, 1'b0, 24'h00000B, 1'b0, 1'b0);
        start <= 1'b0;

        set_scale(16'hFFFF);
        run_phase(PHASE_BEATS, 0);
        set_scale(16'h0001);
        run_phase(PHASE_BEATS, 76);
        set_scale(16'h0000);
        run_phase(PHASE_BEATS, 0);
        set_scale(bpu_t'($urandom_range(1, 65535)));
        wait_drained();
        apb_write(ADDR_UNUSED, $urandom);
        apb_check_read(ADDR_BPU);
        run_phase(PHASE_BEATS, 24);
        set_scale(BPU_RESET);
        run_phase(PHASE_BEATS, 76);
        set_scale(bpu_t'($urandom_range(1, 65535)));
        run_phase(PHASE_BEATS, 24);

        wait_drained();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("bandwidth_counter_accumulator test passed");
        else
            $display("bandwidth_counter_accumulator test failed");
        $finish;
    end

endmodule
